[design/vm3d_pkg.sv]
package vm3d_pkg;

  // Beat payloads
  typedef struct packed {
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
  } in_t;

  typedef struct packed {
    logic [30:0] distance;
    logic        overflow;
  } out_t;

  localparam int unsigned EST_W         = 17;
  localparam int unsigned SQ_W          = 31;
  localparam int unsigned SHIFT_W       = 5;
  localparam int unsigned SCALE_BIAS    = 17;
  localparam int unsigned SEED_BIAS     = 24;
  localparam int unsigned DIV_BITS      = 32;
  localparam int unsigned DIV_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;

  // Item context carried alongside the root datapath
  typedef struct packed {
    logic [SQ_W-1:0]    sq;
    logic [EST_W-1:0]   est;
    logic [SHIFT_W-1:0] shift;
    logic               zero;
    logic               ovf;
    logic               newton;
  } side_t;

  function automatic logic [5:0] clz32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  // Floor square root of an 8-bit index: value k covers k*k .. k*k+2k
  function automatic logic [3:0] root_rom(input logic [7:0] idx);
    logic [3:0] r;
    r = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (int'(idx) >= k * k) r = 4'(k);
    end
    return r;
  endfunction

  // e + floor((q - e) / 2)
  function automatic logic [EST_W-1:0] newton_step(input logic [DIV_BITS-1:0] q,
                                                   input logic [EST_W-1:0] e);
    logic signed [DIV_BITS+1:0] d;
    logic signed [DIV_BITS+1:0] r;
    d = $signed({2'b00, q}) - $signed({{(DIV_BITS+2-EST_W){1'b0}}, e});
    r = $signed({{(DIV_BITS+2-EST_W){1'b0}}, e}) + (d >>> 1);
    return r[EST_W-1:0];
  endfunction

endpackage

[design/vm3d_front.sv]
module vm3d_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  vm3d_pkg::in_t   in_data,
  output logic            out_valid,
  output vm3d_pkg::side_t out_side
);

  // s1: absolute values and their sum
  logic        v1_r;
  logic [31:0] ax1_r, ay1_r, az1_r, sum1_r;
  logic [31:0] ax1_nxt, ay1_nxt, az1_nxt;

  always_comb begin
    ax1_nxt = in_data.comp_x[31] ? 32'(-in_data.comp_x) : in_data.comp_x;
    ay1_nxt = in_data.comp_y[31] ? 32'(-in_data.comp_y) : in_data.comp_y;
    az1_nxt = in_data.comp_z[31] ? 32'(-in_data.comp_z) : in_data.comp_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      ax1_r  <= ax1_nxt;
      ay1_r  <= ay1_nxt;
      az1_r  <= az1_nxt;
      sum1_r <= ax1_nxt + ay1_nxt + az1_nxt;
    end
  end

  // s2: scale down by the headroom of the sum
  logic                         v2_r, zero2_r, ovf2_r;
  logic [vm3d_pkg::SHIFT_W-1:0] sh2_r, sh2_nxt;
  logic [31:0]                  ax2_r, ay2_r, az2_r;
  logic [5:0]                   lz2;

  always_comb begin
    lz2 = vm3d_pkg::clz32(sum1_r);
    if (lz2 < 6'(vm3d_pkg::SCALE_BIAS)) begin
      sh2_nxt = vm3d_pkg::SHIFT_W'(6'(vm3d_pkg::SCALE_BIAS) - lz2);
    end else begin
      sh2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      zero2_r <= (sum1_r == 32'd0);
      ovf2_r  <= sum1_r[31];
      sh2_r   <= sh2_nxt;
      ax2_r   <= 32'($signed(ax1_r) >>> sh2_nxt);
      ay2_r   <= 32'($signed(ay1_r) >>> sh2_nxt);
      az2_r   <= 32'($signed(az1_r) >>> sh2_nxt);
    end
  end

  // s3: squares, low word
  logic                         v3_r, zero3_r, ovf3_r;
  logic [vm3d_pkg::SHIFT_W-1:0] sh3_r;
  logic [31:0]                  qx3_r, qy3_r, qz3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      zero3_r <= zero2_r;
      ovf3_r  <= ovf2_r;
      sh3_r   <= sh2_r;
      qx3_r   <= 32'(ax2_r * ax2_r);
      qy3_r   <= 32'(ay2_r * ay2_r);
      qz3_r   <= 32'(az2_r * az2_r);
    end
  end

  // s4: sum of squares
  logic                         v4_r, zero4_r, ovf4_r;
  logic [vm3d_pkg::SHIFT_W-1:0] sh4_r;
  logic [31:0]                  sq4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
    if (adv) begin
      zero4_r <= zero3_r;
      ovf4_r  <= ovf3_r;
      sh4_r   <= sh3_r;
      sq4_r   <= qx3_r + qy3_r + qz3_r;
    end
  end

  // s5: seed alignment, top byte on an even bit boundary
  logic                         v5_r, zero5_r, ovf5_r, small5_r;
  logic [vm3d_pkg::SHIFT_W-1:0] sh5_r, s5_r;
  logic [31:0]                  sq5_r;
  logic [5:0]                   lz5;

  assign lz5 = vm3d_pkg::clz32(sq4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
    if (adv) begin
      zero5_r  <= zero4_r;
      ovf5_r   <= ovf4_r;
      sh5_r    <= sh4_r;
      sq5_r    <= sq4_r;
      small5_r <= sq4_r[31] | (sq4_r[30:8] == 23'd0);
      s5_r     <= vm3d_pkg::SHIFT_W'(6'(lz5[0]) + 6'(vm3d_pkg::SEED_BIAS) - lz5);
    end
  end

  // s6: seed lookup
  logic            v6_r;
  vm3d_pkg::side_t side6_r, side6_nxt;
  logic [7:0]      idx6;
  logic [31:0]     sqs6;

  always_comb begin
    sqs6             = sq5_r >> s5_r;
    idx6             = small5_r ? sq5_r[7:0] : sqs6[7:0];
    side6_nxt.sq     = sq5_r[vm3d_pkg::SQ_W-1:0];
    side6_nxt.shift  = sh5_r;
    side6_nxt.zero   = zero5_r;
    side6_nxt.ovf    = ovf5_r;
    side6_nxt.newton = !small5_r && !zero5_r && !ovf5_r;
    if (small5_r) begin
      side6_nxt.est = vm3d_pkg::EST_W'(vm3d_pkg::root_rom(idx6));
    end else begin
      side6_nxt.est = vm3d_pkg::EST_W'(vm3d_pkg::root_rom(idx6)) << s5_r[4:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
    if (adv) begin
      side6_r <= side6_nxt;
    end
  end

  assign out_valid = v6_r;
  assign out_side  = side6_r;

endmodule

[design/vm3d_div.sv]
module vm3d_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_valid,
  input  vm3d_pkg::side_t                in_side,
  output logic                           out_valid,
  output logic [vm3d_pkg::DIV_BITS-1:0]  out_quot,
  output vm3d_pkg::side_t                out_side
);

  // Restoring divide of side.sq by side.est, a few quotient bits per stage.
  // The quotient register starts as the dividend and shifts quotient bits in.
  logic                          v_r    [vm3d_pkg::DIV_STAGES];
  logic [vm3d_pkg::EST_W-1:0]    rem_r  [vm3d_pkg::DIV_STAGES];
  logic [vm3d_pkg::DIV_BITS-1:0] quo_r  [vm3d_pkg::DIV_STAGES];
  vm3d_pkg::side_t               side_r [vm3d_pkg::DIV_STAGES];

  for (genvar g = 0; g < vm3d_pkg::DIV_STAGES; g++) begin : g_stage
    logic                          v_in;
    logic [vm3d_pkg::EST_W-1:0]    rem_in, rem_nxt;
    logic [vm3d_pkg::DIV_BITS-1:0] quo_in, quo_nxt;
    vm3d_pkg::side_t               side_in;
    logic [vm3d_pkg::EST_W:0]      trial;

    if (g == 0) begin : g_head
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign quo_in  = {{(vm3d_pkg::DIV_BITS - vm3d_pkg::SQ_W){1'b0}}, in_side.sq};
      assign side_in = in_side;
    end else begin : g_body
      assign v_in    = v_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign side_in = side_r[g-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      trial   = '0;
      for (int k = 0; k < vm3d_pkg::DIV_PER_STAGE; k++) begin
        trial = {rem_nxt, quo_nxt[vm3d_pkg::DIV_BITS-1]};
        if (trial >= {1'b0, side_in.est}) begin
          rem_nxt = vm3d_pkg::EST_W'(trial - {1'b0, side_in.est});
          quo_nxt = {quo_nxt[vm3d_pkg::DIV_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = trial[vm3d_pkg::EST_W-1:0];
          quo_nxt = {quo_nxt[vm3d_pkg::DIV_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (adv) begin
        v_r[g] <= v_in;
      end
      if (adv) begin
        rem_r[g]  <= rem_nxt;
        quo_r[g]  <= quo_nxt;
        side_r[g] <= side_in;
      end
    end
  end

  assign out_valid = v_r[vm3d_pkg::DIV_STAGES-1];
  assign out_quot  = quo_r[vm3d_pkg::DIV_STAGES-1];
  assign out_side  = side_r[vm3d_pkg::DIV_STAGES-1];

endmodule

[design/vector_magnitude_3d_unit.sv]
// Channel  Dir  Handshake             Beat payload
// in_      in   in_valid / in_ready   vm3d_pkg::in_t  (comp_x, comp_y, comp_z)
// out_     out  out_valid / out_ready vm3d_pkg::out_t (distance, overflow)
//
// The path from input beat to output beat runs through six front stages
// (abs/sum, scale, square, square sum, seed align, seed lookup), two
// 8-stage restoring dividers with one Newton update after each, and the
// output register. One beat enters per cycle; throughput is one per clock.
// All stages advance together whenever the output register is empty or
// being drained, so a stall freezes the whole pipe and nothing is lost.
// rst_n is synchronous and clears only the valid bits.
module vector_magnitude_3d_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vm3d_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output vm3d_pkg::out_t out_data
);

  logic adv;

  // Advance the pipe when the output slot is free or taken this cycle
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Front end: abs, scale, squares, seed
  logic            fe_valid;
  vm3d_pkg::side_t fe_side;

  vm3d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (fe_valid),
    .out_side  (fe_side)
  );

  // First Newton step: divide, then update the estimate
  logic                          d1_valid;
  logic [vm3d_pkg::DIV_BITS-1:0] d1_quot;
  vm3d_pkg::side_t               d1_side;

  vm3d_div u_div1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (fe_valid),
    .in_side   (fe_side),
    .out_valid (d1_valid),
    .out_quot  (d1_quot),
    .out_side  (d1_side)
  );

  logic            v7_r;
  vm3d_pkg::side_t side7_r, side7_nxt;

  always_comb begin
    side7_nxt = d1_side;
    if (d1_side.newton) begin
      side7_nxt.est = vm3d_pkg::newton_step(d1_quot, d1_side.est);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= d1_valid;
    end
    if (adv) begin
      side7_r <= side7_nxt;
    end
  end

  // Second Newton step
  logic                          d2_valid;
  logic [vm3d_pkg::DIV_BITS-1:0] d2_quot;
  vm3d_pkg::side_t               d2_side;

  vm3d_div u_div2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v7_r),
    .in_side   (side7_r),
    .out_valid (d2_valid),
    .out_quot  (d2_quot),
    .out_side  (d2_side)
  );

  logic            v8_r;
  vm3d_pkg::side_t side8_r, side8_nxt;

  always_comb begin
    side8_nxt = d2_side;
    if (d2_side.newton) begin
      side8_nxt.est = vm3d_pkg::newton_step(d2_quot, d2_side.est);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (adv) begin
      v8_r <= d2_valid;
    end
    if (adv) begin
      side8_r <= side8_nxt;
    end
  end

  // Output register: undo the scaling, flag sum overflow and results that reach bit 31
  logic           out_valid_r;
  vm3d_pkg::out_t out_data_r, out_data_nxt;
  logic [31:0]    res8;

  always_comb begin
    res8 = {{(32 - vm3d_pkg::EST_W){1'b0}}, side8_r.est} << side8_r.shift;
    if (side8_r.zero) begin
      out_data_nxt.distance = '0;
      out_data_nxt.overflow = 1'b0;
    end else if (side8_r.ovf || res8[31]) begin
      out_data_nxt.distance = '0;
      out_data_nxt.overflow = 1'b1;
    end else begin
      out_data_nxt.distance = res8[30:0];
      out_data_nxt.overflow = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v8_r;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_ovf_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.distance == '0)
    else $error("overflow beat with nonzero distance");

  a_newton_est_pos: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r && side7_r.newton |-> side7_r.est != '0)
    else $error("Newton estimate collapsed to zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed or dropped");
`endif

endmodule

[dv/vector_magnitude_3d_unit_tb.sv]
module vector_magnitude_3d_unit_tb;

  // Pipe depth of the block, scaled up for the final drain.
  localparam int unsigned PIPE_DEPTH     = 25;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_BEATS   = 520;
  localparam int unsigned LONG_HOLD      = 200;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 typed;
    logic [30:0]        distance;
    logic               overflow;
  } vec_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  vm3d_pkg::in_t   in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  vm3d_pkg::out_t  out_data;

  vm3d_pkg::out_t  length_q[$];
  int unsigned error_count = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned overflow_seen = 0;
  int unsigned stall_cycles = 0;
  idle_mode_e  idle_mode = IDLE_NONE;
  bit          hold_recv = 1'b0;

  byte unsigned seed_rom[256];

  always #4 clk = ~clk;

  vector_magnitude_3d_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Seed table: entry k is the floor root, so k covers k*k .. k*k+2k.
  initial begin
    for (int i = 0; i < 256; i++) begin
      seed_rom[i] = 0;
      for (int k = 1; k < 16; k++) begin
        if (i >= k * k) seed_rom[i] = k;
      end
    end
  end

  function automatic int unsigned count_lz(logic [31:0] v);
    int unsigned n;
    n = 0;
    while (n < 32 && v[31 - n] == 1'b0) n++;
    return n;
  endfunction

  function automatic logic [31:0] fold_abs(logic [31:0] v);
    if (v != 0 && !v[31]) return v;
    return 32'd0 - v;
  endfunction

  // One truncating Newton step: e + floor((v / e - e) / 2).
  function automatic longint refine_root(longint v, longint e);
    longint q;
    longint d;
    q = (e != 0) ? v / e : 0;
    d = q - e;
    if (d >= 0) return e + d / 2;
    return e - ((-d + 1) / 2);
  endfunction

  function automatic vm3d_pkg::out_t predict_length(logic [31:0] x, logic [31:0] y,
                                                    logic [31:0] z);
    logic [31:0]     ax, ay, az, sum, sq, res;
    int unsigned     shift, lz, s;
    longint          est;
    vm3d_pkg::out_t  r;
    r = '0;
    ax = fold_abs(x);
    ay = fold_abs(y);
    az = fold_abs(z);
    sum = ax + ay + az;
    if (sum == 0) return r;
    if (sum[31]) begin
      r.overflow = 1'b1;
      return r;
    end
    lz = count_lz(sum);
    shift = (lz < 17) ? 17 - lz : 0;
    ax = $signed(ax) >>> shift;
    ay = $signed(ay) >>> shift;
    az = $signed(az) >>> shift;
    sq = ax * ax + ay * ay + az * az;
    est = seed_rom[sq[7:0]];
    if (!sq[31] && sq >= 32'h100) begin
      lz = count_lz(sq);
      s = (lz & 1) + 24 - lz;
      est = longint'(seed_rom[(sq >> s) & 8'hff]) << (s >> 1);
      est = refine_root(longint'(sq), est);
      est = refine_root(longint'(sq), est);
    end
    res = 32'(est << shift);
    if (res[31]) r.overflow = 1'b1;
    else r.distance = res[30:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_comp();
    // Mix component scales so every shift amount and both sum signs occur.
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15) - 8;
      1: return $urandom_range(0, 65535) - 32768;
      2: return $signed($urandom) >>> $urandom_range(2, 30);
      3: return $signed($urandom) >>> 2;
      4: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return $urandom;
    endcase
  endfunction

  function automatic bit idle_now(bit sender);
    case (idle_mode)
      IDLE_SEND: return sender && ($urandom_range(0, 99) < 57);
      IDLE_RECV: return !sender && ($urandom_range(0, 99) < 57);
      IDLE_BOTH: return $urandom_range(0, 99) < 33;
      default:   return 1'b0;
    endcase
  endfunction

  // Offer one beat, hold it until taken, then record the prediction.
  // Valid stays high after the beat is taken; the caller drops it when done.
  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             bit typed, vm3d_pkg::out_t want);
    vm3d_pkg::out_t p;
    p = predict_length(x, y, z);
    while (idle_now(1'b1)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{comp_x: x, comp_y: y, comp_z: z};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed && p != want) begin
      $error("table row mismatch: distance exp %0d got %0d, overflow exp %0d got %0d",
             want.distance, p.distance, want.overflow, p.overflow);
      error_count++;
    end
    length_q.push_back(typed ? want : p);
    beats_in++;
  endtask

  // Receiver: random stalls, plus the long hold requested by the stimulus.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_recv) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_now(1'b0);
    end
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    vm3d_pkg::out_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (length_q.size() == 0) begin
        $error("result beat with nothing expected: distance %0d overflow %0d",
               out_data.distance, out_data.overflow);
        error_count++;
      end else begin
        e = length_q.pop_front();
        if (out_data.overflow) overflow_seen++;
        if (out_data.distance !== e.distance) begin
          $error("distance: expected %0d, got %0d", e.distance, out_data.distance);
          error_count++;
        end
        if (out_data.overflow !== e.overflow) begin
          $error("overflow: expected %0d, got %0d", e.overflow, out_data.overflow);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", length_q.size());
      $display("vector_magnitude_3d_unit_tb failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted in its own process.
  task automatic hold_receiver();
    hold_recv = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_recv = 1'b0;
  endtask

  task automatic wait_drained();
    while (length_q.size() != 0) @(posedge clk);
  endtask

  vec_row_t rows[$];

  initial begin
    vm3d_pkg::out_t  want;
    vec_row_t        r;
    int              t;

    // Directed rows; expected values typed in only where obvious.
    rows.push_back('{0, 0, 0, 1, 31'd0, 1'b0});
    rows.push_back('{3, 4, 0, 1, 31'd5, 1'b0});
    rows.push_back('{-3, 0, -4, 1, 31'd5, 1'b0});
    rows.push_back('{1, 0, 0, 1, 31'd1, 1'b0});
    rows.push_back('{0, 0, -1, 1, 31'd1, 1'b0});
    rows.push_back('{32'sh8000_0000, 0, 0, 1, 31'd0, 1'b1});
    rows.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 0, 1, 31'd0, 1'b1});
    rows.push_back('{32'sh4000_0000, 32'sh4000_0000, 0, 1, 31'd0, 1'b1});
    rows.push_back('{32'sh7fff_ffff, 0, 0, 0, 31'd0, 1'b0});
    rows.push_back('{-32'sh7fff_ffff, 0, 0, 0, 31'd0, 1'b0});
    rows.push_back('{32'sh2aaa_aaaa, 32'sh2aaa_aaaa, 32'sh2aaa_aaaa, 0, 31'd0, 1'b0});
    rows.push_back('{15, 15, 15, 0, 31'd0, 1'b0});
    rows.push_back('{16, 0, 0, 0, 31'd0, 1'b0});
    rows.push_back('{255, 255, 255, 0, 31'd0, 1'b0});
    rows.push_back('{65535, 0, 0, 0, 31'd0, 1'b0});
    rows.push_back('{65536, 1, 1, 0, 31'd0, 1'b0});
    rows.push_back('{131071, -131071, 0, 0, 31'd0, 1'b0});
    rows.push_back('{-12345678, 23456789, -3456789, 0, 31'd0, 1'b0});
    rows.push_back('{32'sh5555_5555, 32'sh2aaa_aaaa, 0, 0, 31'd0, 1'b0});
    rows.push_back('{-1, -1, -1, 0, 31'd0, 1'b0});
    rows.push_back('{32'sh8000_0000, 32'sh8000_0000, 0, 0, 31'd0, 1'b0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      want.distance = r.distance;
      want.overflow = r.overflow;
      send_vector(r.x, r.y, r.z, r.typed, want);
    end

    // Fill the pipe against a held receiver so the input side stalls.
    fork
      hold_receiver();
      for (int i = 0; i < 60; i++) send_vector(rand_comp(), rand_comp(), rand_comp(), 0, '0);
    join
    // Sender pauses until everything has drained.
    in_valid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_e'(ph);
      for (int i = 0; i < RANDOM_BEATS / 4; i++) begin
        send_vector(rand_comp(), rand_comp(), rand_comp(), 0, '0);
      end
    end
    idle_mode = IDLE_NONE;
    in_valid <= 1'b0;

    wait_drained();
    t = 0;
    while (t < PIPE_DEPTH * 4) begin
      @(posedge clk);
      t++;
    end

    $display("sent %0d vectors, checked %0d lengths (%0d overflow) over four idle mixes",
             beats_in, beats_out, overflow_seen);
    if (error_count == 0 && length_q.size() == 0) begin
      $display("vector_magnitude_3d_unit_tb passed");
    end else begin
      $display("vector_magnitude_3d_unit_tb failed");
    end
    $finish;
  end

endmodule
